>>> src/tqps_pkg.sv
// shared types, codes and sizes of the three-queue priority scheduler
// no dependencies; imported by tqps_ram users and the top level
package tqps_pkg;

   localparam int QUEUE_DEPTH  = 64;
   localparam int URGENT_DEPTH = 2;

   localparam int FUNC_W   = 2;
   localparam int STATUS_W = 2;
   localparam int ACT_W    = 2;
   localparam int ID_W     = 16;
   localparam int FUEL_W   = 8;
   localparam int TIME_W   = 32;
   localparam int CTR_W    = 32;
   localparam int LIMIT_W  = 7;
   localparam int ENTRY_W  = ID_W + TIME_W;

   localparam int PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int URG_PTR_W = $clog2(URGENT_DEPTH);
   localparam int URG_CNT_W = $clog2(URGENT_DEPTH + 1);
   localparam int SUM_W     = ((CNT_W > LIMIT_W) ? CNT_W : LIMIT_W) + 1;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // request codes
   localparam logic [FUNC_W-1:0] FUNC_ARRIVE = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_DEPART = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_SERVE  = 2'd2;

   // outcome codes
   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_REFUSED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FATAL   = 2'd2;

   // service slot activity codes
   localparam logic [ACT_W-1:0] ACT_IDLE      = 2'd0;
   localparam logic [ACT_W-1:0] ACT_ARRIVAL   = 2'd1;
   localparam logic [ACT_W-1:0] ACT_DEPARTURE = 2'd2;

   // which queue a served entry comes from
   localparam logic [1:0] SRC_URGENT = 2'd0;
   localparam logic [1:0] SRC_NORMAL = 2'd1;
   localparam logic [1:0] SRC_DEPART = 2'd2;

   // register indexes
   localparam logic REG_ADMIT_LIMIT = 1'b0;
   localparam logic REG_LOW_FUEL    = 1'b1;

   typedef struct packed {
      logic [FUNC_W-1:0]   func;
      logic [STATUS_W-1:0] status;
      logic [ACT_W-1:0]    activity;
      logic [1:0]          src;
   } ctl_type;

   function automatic logic [CTR_W-1:0] sat_inc(input logic [CTR_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   function automatic logic [CTR_W-1:0] sat_add(input logic [CTR_W-1:0] a,
                                                input logic [CTR_W-1:0] b);
      logic [CTR_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[CTR_W] ? '1 : s[CTR_W-1:0];
   endfunction

endpackage

>>> src/tqps_ram.sv
// generic simple dual-port ram: one write port, one registered read port
// no dependencies
module tqps_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 48
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/three_queue_priority_scheduler.sv
// three-queue strict priority scheduler, top level
// an accepted transaction moves from the decision stage to the response register
// and raises rsp_valid there; a stalled response holds the decision stage too
// throughput: one transaction per cycle unless stalled; each queue memory has one registered read port
// reset (synchronous, active high) empties the queues, clears the counters and
// restores the admission limit 64 and low_fuel_level 1; queue memories are not cleared
module three_queue_priority_scheduler (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [tqps_pkg::FUNC_W-1:0]     req_func,
   input  logic [tqps_pkg::ID_W-1:0]       req_plane_id,
   input  logic [tqps_pkg::FUEL_W-1:0]     req_fuel_level,
   input  logic [tqps_pkg::TIME_W-1:0]     req_plane_start,
   input  logic [tqps_pkg::TIME_W-1:0]     req_now_time,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [tqps_pkg::STATUS_W-1:0]   rsp_status,
   output logic [tqps_pkg::ACT_W-1:0]      rsp_activity,
   output logic [tqps_pkg::ID_W-1:0]       rsp_served_id,
   output logic [tqps_pkg::TIME_W-1:0]     rsp_served_start,
   output logic [tqps_pkg::TIME_W-1:0]     rsp_served_wait,
   output logic [tqps_pkg::CTR_W-1:0]      rsp_arrivals_served,
   output logic [tqps_pkg::CTR_W-1:0]      rsp_departures_served,
   output logic [tqps_pkg::CTR_W-1:0]      rsp_arrivals_refused,
   output logic [tqps_pkg::CTR_W-1:0]      rsp_departures_refused,
   output logic [tqps_pkg::CTR_W-1:0]      rsp_idle_slots,
   output logic [tqps_pkg::CTR_W-1:0]      rsp_arrival_wait_total,
   output logic [tqps_pkg::CTR_W-1:0]      rsp_departure_wait_total,
   // register port
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [tqps_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [tqps_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [tqps_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);

   import tqps_pkg::*;

   // ---------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------
   logic [LIMIT_W-1:0] limit_ff;
   logic [FUEL_W-1:0]  low_fuel_ff;
   logic               csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   // register index sits on address bit 2, byte offset bits are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff    <= LIMIT_W'(64);
         low_fuel_ff <= FUEL_W'(1);
      end else if (csr_wr) begin
         if (paddr[2] == REG_ADMIT_LIMIT) begin
            limit_ff <= pwdata[LIMIT_W-1:0];
         end else begin
            low_fuel_ff <= pwdata[FUEL_W-1:0];
         end
      end
   end

   always_comb begin
      if (paddr[2] == REG_ADMIT_LIMIT) begin
         prdata = {{(CSR_DATA_W-LIMIT_W){1'b0}}, limit_ff};
      end else begin
         prdata = {{(CSR_DATA_W-FUEL_W){1'b0}}, low_fuel_ff};
      end
   end

   // ---------------------------------------------------------------
   // handshake: decision stage then response register
   // ---------------------------------------------------------------
   logic    a_v_ff;
   ctl_type a_ctl_ff;
   ctl_type a_ctl_in;
   logic [TIME_W-1:0] a_now_ff;
   logic    rsp_valid_ff;
   logic    accept;
   logic    advance;

   assign advance   = a_v_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = a_v_ff && !advance;
   assign accept    = req_valid && !req_stall;

   // ---------------------------------------------------------------
   // queue occupancy and pointers
   // ---------------------------------------------------------------
   logic [URG_CNT_W-1:0] urg_cnt_ff, urg_cnt_in;
   logic [CNT_W-1:0]     nrm_cnt_ff, nrm_cnt_in;
   logic [CNT_W-1:0]     dep_cnt_ff, dep_cnt_in;
   logic [URG_PTR_W-1:0] urg_head_ff, urg_head_in, urg_tail_ff, urg_tail_in;
   logic [PTR_W-1:0]     nrm_head_ff, nrm_head_in, nrm_tail_ff, nrm_tail_in;
   logic [PTR_W-1:0]     dep_head_ff, dep_head_in, dep_tail_ff, dep_tail_in;

   logic [SUM_W-1:0] arr_sum;
   logic arr_fatal, arr_room, to_urgent;
   logic push_urg, push_nrm, push_dep;
   logic pop_urg, pop_nrm, pop_dep;
   logic is_arrive, is_depart, is_serve;

   assign is_arrive = (req_func == FUNC_ARRIVE);
   assign is_depart = (req_func == FUNC_DEPART);
   assign is_serve  = (req_func == FUNC_SERVE);

   // fatal once the urgent queue holds more than one entry
   assign arr_fatal = (urg_cnt_ff > URG_CNT_W'(1));
   assign arr_sum   = SUM_W'(urg_cnt_ff) + SUM_W'(nrm_cnt_ff);
   assign arr_room  = (arr_sum < SUM_W'(limit_ff));
   assign to_urgent = (req_fuel_level <= low_fuel_ff);

   // a full normal or departure store refuses as if the limit were met
   assign push_urg = is_arrive && !arr_fatal && arr_room && to_urgent &&
                     (urg_cnt_ff < URG_CNT_W'(URGENT_DEPTH));
   assign push_nrm = is_arrive && !arr_fatal && arr_room && !to_urgent &&
                     (nrm_cnt_ff < CNT_W'(QUEUE_DEPTH));
   assign push_dep = is_depart &&
                     (SUM_W'(dep_cnt_ff) < SUM_W'(limit_ff)) &&
                     (dep_cnt_ff < CNT_W'(QUEUE_DEPTH));

   // strict priority: urgent, normal, departure
   assign pop_urg = is_serve && (urg_cnt_ff != '0);
   assign pop_nrm = is_serve && (urg_cnt_ff == '0) && (nrm_cnt_ff != '0);
   assign pop_dep = is_serve && (urg_cnt_ff == '0) && (nrm_cnt_ff == '0) &&
                    (dep_cnt_ff != '0);

   always_comb begin
      a_ctl_in.func     = req_func;
      a_ctl_in.status   = STATUS_OK;
      a_ctl_in.activity = ACT_IDLE;
      a_ctl_in.src      = SRC_URGENT;
      case (req_func)
         FUNC_ARRIVE: begin
            if (arr_fatal) begin
               a_ctl_in.status = STATUS_FATAL;
            end else if (!(push_urg || push_nrm)) begin
               a_ctl_in.status = STATUS_REFUSED;
            end
         end
         FUNC_DEPART: begin
            if (!push_dep) begin
               a_ctl_in.status = STATUS_REFUSED;
            end
         end
         FUNC_SERVE: begin
            if (pop_urg) begin
               a_ctl_in.activity = ACT_ARRIVAL;
               a_ctl_in.src      = SRC_URGENT;
            end else if (pop_nrm) begin
               a_ctl_in.activity = ACT_ARRIVAL;
               a_ctl_in.src      = SRC_NORMAL;
            end else if (pop_dep) begin
               a_ctl_in.activity = ACT_DEPARTURE;
               a_ctl_in.src      = SRC_DEPART;
            end
         end
         default: begin
            // unused code: no change, all-zero outcome
         end
      endcase
   end

   always_comb begin
      urg_cnt_in  = urg_cnt_ff;
      nrm_cnt_in  = nrm_cnt_ff;
      dep_cnt_in  = dep_cnt_ff;
      urg_head_in = urg_head_ff;
      urg_tail_in = urg_tail_ff;
      nrm_head_in = nrm_head_ff;
      nrm_tail_in = nrm_tail_ff;
      dep_head_in = dep_head_ff;
      dep_tail_in = dep_tail_ff;
      if (push_urg) begin
         urg_cnt_in  = urg_cnt_ff + 1'b1;
         urg_tail_in = (urg_tail_ff == URG_PTR_W'(URGENT_DEPTH - 1)) ? '0 : urg_tail_ff + 1'b1;
      end
      if (pop_urg) begin
         urg_cnt_in  = urg_cnt_ff - 1'b1;
         urg_head_in = (urg_head_ff == URG_PTR_W'(URGENT_DEPTH - 1)) ? '0 : urg_head_ff + 1'b1;
      end
      if (push_nrm) begin
         nrm_cnt_in  = nrm_cnt_ff + 1'b1;
         nrm_tail_in = (nrm_tail_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : nrm_tail_ff + 1'b1;
      end
      if (pop_nrm) begin
         nrm_cnt_in  = nrm_cnt_ff - 1'b1;
         nrm_head_in = (nrm_head_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : nrm_head_ff + 1'b1;
      end
      if (push_dep) begin
         dep_cnt_in  = dep_cnt_ff + 1'b1;
         dep_tail_in = (dep_tail_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : dep_tail_ff + 1'b1;
      end
      if (pop_dep) begin
         dep_cnt_in  = dep_cnt_ff - 1'b1;
         dep_head_in = (dep_head_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : dep_head_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         urg_cnt_ff  <= '0;
         nrm_cnt_ff  <= '0;
         dep_cnt_ff  <= '0;
         urg_head_ff <= '0;
         urg_tail_ff <= '0;
         nrm_head_ff <= '0;
         nrm_tail_ff <= '0;
         dep_head_ff <= '0;
         dep_tail_ff <= '0;
      end else if (accept) begin
         urg_cnt_ff  <= urg_cnt_in;
         nrm_cnt_ff  <= nrm_cnt_in;
         dep_cnt_ff  <= dep_cnt_in;
         urg_head_ff <= urg_head_in;
         urg_tail_ff <= urg_tail_in;
         nrm_head_ff <= nrm_head_in;
         nrm_tail_ff <= nrm_tail_in;
         dep_head_ff <= dep_head_in;
         dep_tail_ff <= dep_tail_in;
      end
   end

   // ---------------------------------------------------------------
   // queue stores: entry is {plane_id, plane_start}
   // head entry is read at acceptance, held until the next service slot
   // ---------------------------------------------------------------
   logic [ENTRY_W-1:0] req_entry;
   logic [ENTRY_W-1:0] urg_rd, nrm_rd, dep_rd;

   assign req_entry = {req_plane_id, req_plane_start};

   tqps_ram #(.DEPTH(URGENT_DEPTH), .WIDTH(ENTRY_W)) u_urgent_ram (
      .clock   (clock),
      .wr_en   (accept && push_urg),
      .wr_addr (urg_tail_ff),
      .wr_data (req_entry),
      .rd_en   (accept && pop_urg),
      .rd_addr (urg_head_ff),
      .rd_data (urg_rd)
   );

   tqps_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH(ENTRY_W)) u_normal_ram (
      .clock   (clock),
      .wr_en   (accept && push_nrm),
      .wr_addr (nrm_tail_ff),
      .wr_data (req_entry),
      .rd_en   (accept && pop_nrm),
      .rd_addr (nrm_head_ff),
      .rd_data (nrm_rd)
   );

   tqps_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH(ENTRY_W)) u_depart_ram (
      .clock   (clock),
      .wr_en   (accept && push_dep),
      .wr_addr (dep_tail_ff),
      .wr_data (req_entry),
      .rd_en   (accept && pop_dep),
      .rd_addr (dep_head_ff),
      .rd_data (dep_rd)
   );

   // ---------------------------------------------------------------
   // decision stage register
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
      end else if (accept) begin
         a_v_ff <= 1'b1;
      end else if (advance) begin
         a_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_ctl_ff <= a_ctl_in;
         a_now_ff <= req_now_time;
      end
   end

   // ---------------------------------------------------------------
   // served entry, wait and statistics
   // ---------------------------------------------------------------
   logic [ENTRY_W-1:0] sel_entry;
   logic [ID_W-1:0]    sel_id;
   logic [TIME_W-1:0]  sel_start;
   logic [TIME_W-1:0]  sel_wait;
   logic               served;

   always_comb begin
      case (a_ctl_ff.src)
         SRC_URGENT: sel_entry = urg_rd;
         SRC_NORMAL: sel_entry = nrm_rd;
         SRC_DEPART: sel_entry = dep_rd;
         default:    sel_entry = dep_rd;
      endcase
   end

   assign served    = (a_ctl_ff.activity != ACT_IDLE);
   assign sel_id    = sel_entry[ENTRY_W-1:TIME_W];
   assign sel_start = sel_entry[TIME_W-1:0];
   assign sel_wait  = a_now_ff - sel_start;

   logic [CTR_W-1:0] arr_served_ff, dep_served_ff, arr_refused_ff, dep_refused_ff;
   logic [CTR_W-1:0] idle_ff, arr_wait_ff, dep_wait_ff;

   // counters move only when a transaction enters the response register,
   // so they read as the values after that transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         arr_served_ff  <= '0;
         dep_served_ff  <= '0;
         arr_refused_ff <= '0;
         dep_refused_ff <= '0;
         idle_ff        <= '0;
         arr_wait_ff    <= '0;
         dep_wait_ff    <= '0;
      end else if (advance) begin
         if (a_ctl_ff.status == STATUS_REFUSED) begin
            if (a_ctl_ff.func == FUNC_ARRIVE) begin
               arr_refused_ff <= sat_inc(arr_refused_ff);
            end else begin
               dep_refused_ff <= sat_inc(dep_refused_ff);
            end
         end
         if (a_ctl_ff.func == FUNC_SERVE) begin
            case (a_ctl_ff.activity)
               ACT_ARRIVAL: begin
                  arr_served_ff <= sat_inc(arr_served_ff);
                  arr_wait_ff   <= sat_add(arr_wait_ff, sel_wait);
               end
               ACT_DEPARTURE: begin
                  dep_served_ff <= sat_inc(dep_served_ff);
                  dep_wait_ff   <= sat_add(dep_wait_ff, sel_wait);
               end
               default: begin
                  idle_ff <= sat_inc(idle_ff);
               end
            endcase
         end
      end
   end

   // ---------------------------------------------------------------
   // response register
   // ---------------------------------------------------------------
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [ACT_W-1:0]    rsp_activity_ff;
   logic [ID_W-1:0]     rsp_id_ff;
   logic [TIME_W-1:0]   rsp_start_ff;
   logic [TIME_W-1:0]   rsp_wait_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_status_ff   <= a_ctl_ff.status;
         rsp_activity_ff <= a_ctl_ff.activity;
         rsp_id_ff       <= served ? sel_id : '0;
         rsp_start_ff    <= served ? sel_start : '0;
         rsp_wait_ff     <= served ? sel_wait : '0;
      end
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_status               = rsp_status_ff;
   assign rsp_activity             = rsp_activity_ff;
   assign rsp_served_id            = rsp_id_ff;
   assign rsp_served_start         = rsp_start_ff;
   assign rsp_served_wait          = rsp_wait_ff;
   assign rsp_arrivals_served      = arr_served_ff;
   assign rsp_departures_served    = dep_served_ff;
   assign rsp_arrivals_refused     = arr_refused_ff;
   assign rsp_departures_refused   = dep_refused_ff;
   assign rsp_idle_slots           = idle_ff;
   assign rsp_arrival_wait_total   = arr_wait_ff;
   assign rsp_departure_wait_total = dep_wait_ff;

   // ---------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------
   // occupancy never passes the store sizes
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (urg_cnt_ff <= URG_CNT_W'(URGENT_DEPTH)) && (nrm_cnt_ff <= CNT_W'(QUEUE_DEPTH)) &&
      (dep_cnt_ff <= CNT_W'(QUEUE_DEPTH)))
      else $error("queue occupancy beyond store size");

   // an arrival against a full urgent queue is fatal
   a_fatal: assert property (@(posedge clock) disable iff (reset)
      (accept && is_arrive && (urg_cnt_ff == URG_CNT_W'(URGENT_DEPTH)))
      |=> (a_ctl_ff.status == STATUS_FATAL))
      else $error("urgent overflow not reported as fatal");

   // a slot with all queues empty is idle
   a_idle: assert property (@(posedge clock) disable iff (reset)
      (accept && is_serve && (urg_cnt_ff == '0) && (nrm_cnt_ff == '0) &&
       (dep_cnt_ff == '0)) |=> (a_ctl_ff.activity == ACT_IDLE))
      else $error("service slot on empty queues not idle");

   // a reported served arrival is counted
   a_arr_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_activity == ACT_ARRIVAL)) |-> (rsp_arrivals_served != '0))
      else $error("served arrival missing from counter");

endmodule
